// File: rtl/core/crp_pkg.sv
package crp_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int COORD_W     = 20;
   localparam int TRIG_W      = 16;
   localparam int CORD_W      = 24;
   localparam int CZ_W        = 18;
   localparam int CORD_STAGES = 14;
   localparam int CORD_GAIN   = 636751;
   localparam int PROD_W      = 36;
   localparam int NUM_W       = 36;
   localparam int DEN_W       = 21;
   localparam int OUT_W       = 24;
   localparam int DIV_CNT_W   = 6;
   localparam int VIEW_RESET  = 25600;

   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;
   localparam logic [1:0] REG_VIEW     = 2'd3;

   localparam logic [1:0] CMD_NONE = 2'd0;

   typedef enum logic [1:0] {
      MIX_NONE,
      MIX_PROD_A,
      MIX_PROD_B,
      MIX_ACC
   } mix_op_type;

   typedef struct packed {
      logic       angle_upd;
      logic       cord_init;
      logic       cord_step;
      logic       cord_save;
      logic [1:0] axis;
      logic [3:0] iter;
      logic       corner_load;
      logic [2:0] corner;
      mix_op_type mix_op;
      logic [2:0] mix_idx;
      logic       div_load;
      logic       div_step;
      logic       div_save;
      logic       sel_y;
      logic       out_load;
   } crp_cmd_type;

   typedef struct packed {
      logic den_pos;
   } crp_status_type;

   // atan(2^-i), 65536 per turn
   function automatic logic [CZ_W-1:0] atan_lut(input logic [3:0] i);
      logic [CZ_W-1:0] r;
      case (i)
         4'd0:    r = CZ_W'(8192);
         4'd1:    r = CZ_W'(4836);
         4'd2:    r = CZ_W'(2555);
         4'd3:    r = CZ_W'(1297);
         4'd4:    r = CZ_W'(651);
         4'd5:    r = CZ_W'(326);
         4'd6:    r = CZ_W'(163);
         4'd7:    r = CZ_W'(81);
         4'd8:    r = CZ_W'(41);
         4'd9:    r = CZ_W'(20);
         4'd10:   r = CZ_W'(10);
         4'd11:   r = CZ_W'(5);
         4'd12:   r = CZ_W'(3);
         4'd13:   r = CZ_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // sign bits of a corner: {z, y, x}, 1 = -1
   function automatic logic [2:0] corner_neg(input logic [2:0] k);
      return {k[2], k[1], k[1] ^ k[0]};
   endfunction

endpackage

// File: rtl/core/crp_ctrl.sv
module crp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  crp_pkg::crp_status_type status,
   output crp_pkg::crp_cmd_type    cmd
);
   import crp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CORD_INIT,
      S_CORD_ITER,
      S_CORD_SAVE,
      S_CORNER,
      S_MIX_A,
      S_MIX_B,
      S_MIX_ACC,
      S_DIV_LOAD,
      S_DIV_ITER,
      S_DIV_SAVE,
      S_EMIT,
      S_OUT
   } state_type;

   state_type            state_ff;
   logic                 ready_ff;
   logic                 valid_ff;
   logic [1:0]           axis_ff;
   logic [3:0]           iter_ff;
   logic [2:0]           corner_ff;
   logic [2:0]           mix_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 sel_y_ff;

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.mix_op      = MIX_NONE;
      cmd.axis        = axis_ff;
      cmd.iter        = iter_ff;
      cmd.corner      = corner_ff;
      cmd.mix_idx     = mix_ff;
      cmd.sel_y       = sel_y_ff;
      case (state_ff)
         S_IDLE:      cmd.angle_upd   = req_tvalid && ready_ff;
         S_CORD_INIT: cmd.cord_init   = 1'b1;
         S_CORD_ITER: cmd.cord_step   = 1'b1;
         S_CORD_SAVE: cmd.cord_save   = 1'b1;
         S_CORNER:    cmd.corner_load = 1'b1;
         S_MIX_A:     cmd.mix_op      = MIX_PROD_A;
         S_MIX_B:     cmd.mix_op      = MIX_PROD_B;
         S_MIX_ACC:   cmd.mix_op      = MIX_ACC;
         S_DIV_LOAD:  cmd.div_load    = status.den_pos;
         S_DIV_ITER:  cmd.div_step    = 1'b1;
         S_DIV_SAVE:  cmd.div_save    = 1'b1;
         S_EMIT:      cmd.out_load    = 1'b1;
         default:     cmd.mix_op      = MIX_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ready_ff   <= 1'b1;
         valid_ff   <= 1'b0;
         axis_ff    <= '0;
         iter_ff    <= '0;
         corner_ff  <= '0;
         mix_ff     <= '0;
         div_cnt_ff <= '0;
         sel_y_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  ready_ff <= 1'b0;
                  axis_ff  <= '0;
                  state_ff <= S_CORD_INIT;
               end
            end
            S_CORD_INIT: begin
               iter_ff  <= '0;
               state_ff <= S_CORD_ITER;
            end
            S_CORD_ITER: begin
               if (iter_ff == 4'(CORD_STAGES - 1)) begin
                  state_ff <= S_CORD_SAVE;
               end else begin
                  iter_ff <= iter_ff + 4'd1;
               end
            end
            S_CORD_SAVE: begin
               if (axis_ff == 2'd2) begin
                  corner_ff <= '0;
                  state_ff  <= S_CORNER;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_CORD_INIT;
               end
            end
            S_CORNER: begin
               mix_ff   <= '0;
               state_ff <= S_MIX_A;
            end
            S_MIX_A: state_ff <= S_MIX_B;
            S_MIX_B: state_ff <= S_MIX_ACC;
            S_MIX_ACC: begin
               if (mix_ff == 3'd5) begin
                  sel_y_ff <= 1'b0;
                  state_ff <= S_DIV_LOAD;
               end else begin
                  mix_ff   <= mix_ff + 3'd1;
                  state_ff <= S_MIX_A;
               end
            end
            S_DIV_LOAD: begin
               div_cnt_ff <= '0;
               state_ff   <= status.den_pos ? S_DIV_ITER : S_EMIT;
            end
            S_DIV_ITER: begin
               if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
                  state_ff <= S_DIV_SAVE;
               end else begin
                  div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               end
            end
            S_DIV_SAVE: begin
               if (sel_y_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  sel_y_ff <= 1'b1;
                  state_ff <= S_DIV_LOAD;
               end
            end
            S_EMIT: begin
               valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  valid_ff <= 1'b0;
                  if (corner_ff == 3'd7) begin
                     ready_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     corner_ff <= corner_ff + 3'd1;
                     state_ff  <= S_CORNER;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/crp_dpath.sv
module crp_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  crp_pkg::crp_cmd_type                cmd,
   output crp_pkg::crp_status_type             status,
   input  logic [1:0]                          command,
   input  logic signed [15:0]                  angle_step,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_index,
   input  logic [15:0]                         csr_data,
   output logic [2:0]                          corner_index,
   output logic signed [crp_pkg::OUT_W-1:0]    screen_x,
   output logic signed [crp_pkg::OUT_W-1:0]    screen_y,
   output logic                                behind_viewer,
   output logic                                last_corner
);
   import crp_pkg::*;

   // configuration
   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;
   logic [15:0]        view_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
         view_ff  <= 16'(VIEW_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            REG_OFFSET_X: off_x_ff <= csr_data;
            REG_OFFSET_Y: off_y_ff <= csr_data;
            REG_OFFSET_Z: off_z_ff <= csr_data;
            REG_VIEW:     view_ff  <= csr_data;
            default:      view_ff  <= view_ff;
         endcase
      end
   end

   // angles
   logic [ANGLE_BITS-1:0] angle_ff [3];
   logic signed [31:0]    step_wide;
   logic [1:0]            upd_axis;

   assign step_wide = 32'(angle_step);
   assign upd_axis  = command - 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff[0] <= '0;
         angle_ff[1] <= '0;
         angle_ff[2] <= '0;
      end else if (cmd.angle_upd && command != CMD_NONE) begin
         angle_ff[upd_axis] <= angle_ff[upd_axis] + step_wide[ANGLE_BITS-1:0];
      end
   end

   // cordic
   logic [31:0]              phase_wide;
   logic [15:0]              phase;
   logic signed [CORD_W-1:0] cx_ff, cy_ff;
   logic signed [CZ_W-1:0]   cz_ff;
   logic [1:0]               quad_ff;
   logic signed [CORD_W-1:0] dx, dy;
   logic signed [CZ_W-1:0]   atan_v;
   logic signed [TRIG_W-1:0] cr, sr, sin_in, cos_in;
   logic signed [TRIG_W-1:0] sin_ff [3];
   logic signed [TRIG_W-1:0] cos_ff [3];

   function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CORD_W-1:0] v);
      logic signed [CORD_W:0]   s;
      logic signed [CORD_W-6:0] r;
      s = (CORD_W+1)'(v) + (CORD_W+1)'(32);
      r = (CORD_W-5)'(s >>> 6);
      if (r > (CORD_W-5)'(16384)) begin
         r = (CORD_W-5)'(16384);
      end else if (r < -(CORD_W-5)'(16384)) begin
         r = -(CORD_W-5)'(16384);
      end
      return TRIG_W'(r);
   endfunction

   assign phase_wide = {angle_ff[cmd.axis], {(32 - ANGLE_BITS){1'b0}}};
   assign phase      = phase_wide[31:16];
   assign dx         = cy_ff >>> cmd.iter;
   assign dy         = cx_ff >>> cmd.iter;
   assign atan_v     = atan_lut(cmd.iter);
   assign cr         = to_q14(cx_ff);
   assign sr         = to_q14(cy_ff);

   always_comb begin
      case (quad_ff)
         2'd0:    begin sin_in = sr;  cos_in = cr;  end
         2'd1:    begin sin_in = cr;  cos_in = -sr; end
         2'd2:    begin sin_in = -sr; cos_in = -cr; end
         default: begin sin_in = -cr; cos_in = sr;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.cord_init) begin
         cx_ff   <= CORD_W'(CORD_GAIN);
         cy_ff   <= '0;
         cz_ff   <= CZ_W'(phase[13:0]);
         quad_ff <= phase[15:14];
      end else if (cmd.cord_step) begin
         if (!cz_ff[CZ_W-1]) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_v;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_v;
         end
      end
      if (cmd.cord_save) begin
         sin_ff[cmd.axis] <= sin_in;
         cos_ff[cmd.axis] <= cos_in;
      end
   end

   // rotation
   logic signed [COORD_W-1:0] rx_ff, ry_ff, rz_ff, t_ff;
   logic [2:0]                neg;
   logic signed [COORD_W-1:0] op_a, op_b, mul_c;
   logic signed [TRIG_W-1:0]  trig_s, trig_c, op_ca, op_cb, mul_t;
   logic signed [PROD_W-1:0]  prod_a_ff, prod_b_ff, mul_p;
   logic signed [PROD_W:0]    mix_sum;
   logic signed [COORD_W-1:0] mix_res;
   logic [1:0]                trig_axis;

   assign neg       = corner_neg(cmd.corner);
   assign trig_axis = cmd.mix_idx[2:1];
   assign trig_s    = sin_ff[trig_axis];
   assign trig_c    = cos_ff[trig_axis];
   assign op_a      = (cmd.mix_idx < 3'd2) ? ry_ff : rx_ff;
   assign op_b      = (cmd.mix_idx < 3'd4) ? rz_ff : ry_ff;
   assign op_ca     = cmd.mix_idx[0] ? trig_s : trig_c;
   assign op_cb     = cmd.mix_idx[0] ? trig_c : trig_s;
   assign mul_c     = (cmd.mix_op == MIX_PROD_A) ? op_a : op_b;
   assign mul_t     = (cmd.mix_op == MIX_PROD_A) ? op_ca : op_cb;
   assign mul_p     = PROD_W'(mul_c * mul_t);
   assign mix_sum   = (cmd.mix_idx[0] ? (PROD_W+1)'(prod_a_ff) + (PROD_W+1)'(prod_b_ff)
                                      : (PROD_W+1)'(prod_a_ff) - (PROD_W+1)'(prod_b_ff))
                      + (PROD_W+1)'(8192);
   assign mix_res   = COORD_W'(mix_sum >>> 14);

   always_ff @(posedge clock) begin
      if (cmd.corner_load) begin
         rx_ff <= (neg[0] ? -COORD_W'(256) : COORD_W'(256)) + COORD_W'(off_x_ff);
         ry_ff <= (neg[1] ? -COORD_W'(256) : COORD_W'(256)) + COORD_W'(off_y_ff);
         rz_ff <= (neg[2] ? -COORD_W'(256) : COORD_W'(256)) + COORD_W'(off_z_ff);
      end else if (cmd.mix_op == MIX_ACC) begin
         case (cmd.mix_idx)
            3'd1:    begin rz_ff <= mix_res; ry_ff <= t_ff; end
            3'd3:    begin rz_ff <= mix_res; rx_ff <= t_ff; end
            3'd5:    begin ry_ff <= mix_res; rx_ff <= t_ff; end
            default: t_ff <= mix_res;
         endcase
      end
      if (cmd.mix_op == MIX_PROD_A) begin
         prod_a_ff <= mul_p;
      end
      if (cmd.mix_op == MIX_PROD_B) begin
         prod_b_ff <= mul_p;
      end
   end

   // projection and serial divide
   logic signed [DEN_W-1:0]   den;
   logic                      den_pos;
   logic signed [COORD_W-1:0] src;
   logic [COORD_W-1:0]        src_mag;
   logic [NUM_W-1:0]          num;
   logic [NUM_W-1:0]          quo_ff;
   logic [DEN_W-2:0]          rem_ff;
   logic                      neg_ff;
   logic [DEN_W-1:0]          rem_sh;
   logic                      q_bit;
   logic signed [OUT_W-1:0]   sat_in;
   logic signed [OUT_W-1:0]   px_ff, py_ff;

   assign den     = DEN_W'(rz_ff) + DEN_W'({1'b0, view_ff});
   assign den_pos = !den[DEN_W-1] && (den != '0);
   assign status.den_pos = den_pos;
   assign src     = cmd.sel_y ? ry_ff : rx_ff;
   assign src_mag = src[COORD_W-1] ? COORD_W'(-src) : COORD_W'(src);
   assign num     = NUM_W'(view_ff * src_mag);
   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign q_bit   = (rem_sh >= den);

   always_comb begin
      if (neg_ff) begin
         sat_in = (quo_ff > NUM_W'(8388608)) ? OUT_W'(24'h800000) : OUT_W'(-quo_ff);
      end else begin
         sat_in = (quo_ff > NUM_W'(8388607)) ? OUT_W'(24'h7FFFFF) : OUT_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= num;
         rem_ff <= '0;
         neg_ff <= src[COORD_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? (DEN_W-1)'(rem_sh - den) : (DEN_W-1)'(rem_sh);
         quo_ff <= {quo_ff[NUM_W-2:0], q_bit};
      end
      if (cmd.div_save) begin
         if (cmd.sel_y) begin
            py_ff <= sat_in;
         end else begin
            px_ff <= sat_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         corner_index  <= cmd.corner;
         screen_x      <= den_pos ? px_ff : '0;
         screen_y      <= den_pos ? py_ff : '0;
         behind_viewer <= !den_pos;
         last_corner   <= (cmd.corner == 3'd7);
      end
   end

endmodule

// File: rtl/core/cube_rotate_project_core.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata angle_step, tuser command
// rsp     | out | rsp_tvalid/rsp_tready | tdata corner/x/y, tuser behind, tlast
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// One request at a time; eight responses follow, last one with tlast.
// Each request runs the iterative CORDIC for three angles (14 steps plus
// load and save each), then per corner: load and run six rotation mixes on
// one shared multiplier, two 36-step serial divides (skipped behind the
// viewer) and present the result.
// Synchronous active-high reset; angles cleared, view distance 100.0.
// Response stalls hold the pipeline; csr writes are always taken.
module cube_rotate_project_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] angle_step
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [2:0] corner_index, [26:3] screen_x, [50:27] screen_y
   output logic        rsp_tuser,   // [0] behind_viewer
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import crp_pkg::*;

   crp_cmd_type             cmd;
   crp_status_type          status;
   logic [2:0]              corner_index;
   logic signed [OUT_W-1:0] screen_x, screen_y;
   logic                    behind_viewer;
   logic                    last_corner;

   assign csr_ready = 1'b1;

   crp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   crp_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .command       (req_tuser),
      .angle_step    (req_tdata),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .corner_index  (corner_index),
      .screen_x      (screen_x),
      .screen_y      (screen_y),
      .behind_viewer (behind_viewer),
      .last_corner   (last_corner)
   );

   assign rsp_tdata = {5'd0, screen_y, screen_x, corner_index};
   assign rsp_tuser = behind_viewer;
   assign rsp_tlast = last_corner;

endmodule

// File: rtl/core/crp_checker.sv
module crp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed under stall");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready after last corner");

endmodule

bind cube_rotate_project_core crp_checker u_crp_checker (.*);
